### rtl/core/bloomf_pkg.sv
package bloomf_pkg;

   // Filter geometry. FILTER_BITS must be a power of two (64 to 65536).
   localparam int FILTER_BITS = 1024;
   localparam int NUM_HASHES  = 4;

   localparam int IDX_W       = $clog2(FILTER_BITS);
   localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int K_W         = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

   localparam int ID_W        = 64;
   localparam int HASH_STEPS  = ID_W / 8;

   localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;

   typedef enum logic [2:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_INSERT = 3'd1,
      FUNC_QUERY  = 3'd2,
      FUNC_READ   = 3'd3,
      FUNC_WRITE  = 3'd4
   } func_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the accepted request
      logic clear;      // drop every byte of the store
      logic byte_wr;    // byte write at the request address
      logic rd_done;    // latch the byte read result
      logic hash;       // one FNV-1a byte step on both hashes
      logic hash_last;  // last hash step: seed the probe index with h1
      logic probe_upd;  // consume a probed byte, step the index by h2
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      func_type func;
      logic     ins_ok;
   } stat_type;

   // One FNV-1a step kept to the low IDX_W bits. The low bits of a product
   // and of an xor depend only on the low bits of the operands, so this
   // gives the masked bit index exactly.
   function automatic logic [IDX_W-1:0] fnv_step(input logic [IDX_W-1:0] h,
                                                 input logic [7:0] b);
      logic [IDX_W-1:0] x;
      x = h ^ IDX_W'(b);
      return IDX_W'(x * IDX_W'(FNV_PRIME));
   endfunction

endpackage

### rtl/core/bloomf_ctrl.sv
module bloomf_ctrl
   import bloomf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DECODE    = 7'b0000010,
      S_RD_DONE   = 7'b0000100,
      S_HASH      = 7'b0001000,
      S_PROBE_RD  = 7'b0010000,
      S_PROBE_UPD = 7'b0100000,
      S_RESP      = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       byte_cnt_ff, byte_cnt_in;
   logic [K_W-1:0]   probe_cnt_ff, probe_cnt_in;

   always_comb begin
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;
      probe_cnt_in = probe_cnt_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            byte_cnt_in = '0;
            case (stat.func)
               FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_RESP;
               end
               FUNC_WRITE: begin
                  cmd.byte_wr = 1'b1;
                  state_in    = S_RESP;
               end
               FUNC_READ: begin
                  state_in = S_RD_DONE;
               end
               FUNC_INSERT: begin
                  state_in = stat.ins_ok ? S_HASH : S_RESP;
               end
               FUNC_QUERY: begin
                  state_in = S_HASH;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RD_DONE: begin
            cmd.rd_done = 1'b1;
            state_in    = S_RESP;
         end
         S_HASH: begin
            cmd.hash    = 1'b1;
            byte_cnt_in = byte_cnt_ff + 3'd1;
            if (byte_cnt_ff == 3'(HASH_STEPS - 1)) begin
               cmd.hash_last = 1'b1;
               probe_cnt_in  = '0;
               state_in      = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_UPD;
         end
         S_PROBE_UPD: begin
            cmd.probe_upd = 1'b1;
            probe_cnt_in  = probe_cnt_ff + K_W'(1);
            state_in      = (probe_cnt_ff == K_W'(NUM_HASHES - 1)) ? S_RESP : S_PROBE_RD;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         byte_cnt_ff  <= '0;
         probe_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         probe_cnt_ff <= probe_cnt_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready for a request while a response is pending");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted beat not followed by decode");

   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.probe_upd && probe_cnt_ff == K_W'(NUM_HASHES - 1)) |=> rsp_tvalid)
      else $error("last probe did not lead to a response");

endmodule

### rtl/core/bloomf_dp.sv
module bloomf_dp
   import bloomf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [ID_W-1:0]  csr_data,
   input  logic [2:0]       req_func,
   input  logic [ID_W-1:0]  req_node_id,
   input  logic             req_uplink,
   input  logic [6:0]       req_byte_index,
   input  logic [7:0]       req_byte_data,
   input  cmd_type          cmd,
   output stat_type         stat,
   output logic             hit,
   output logic [7:0]       read_data
);

   logic [ID_W-1:0]   salt_ff;
   func_type          func_ff;
   logic [ID_W-1:0]   id1_ff, id2_ff;
   logic              uplink_ff, id_nz_ff;
   logic [6:0]        addr_ff;
   logic [7:0]        data_ff;
   logic [IDX_W-1:0]  h1_ff, h2_ff, acc_ff;
   logic [IDX_W-1:0]  h1_in, h2_in;
   logic              hit_ff;
   logic [7:0]        rd_ff;

   logic [7:0]              mem [STORE_BYTES];
   logic [STORE_BYTES-1:0]  vld_ff;
   logic [7:0]              mem_q_ff;
   logic                    vld_q_ff;

   logic              is_probe;
   logic              addr_ok;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic [7:0]        byte_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         salt_ff <= '0;
      end else if (csr_we) begin
         salt_ff <= csr_data;
      end
   end

   assign h1_in = fnv_step(h1_ff, id1_ff[ID_W-1 -: 8]);
   assign h2_in = fnv_step(h2_ff, id2_ff[ID_W-1 -: 8]);

   assign is_probe  = (func_ff == FUNC_INSERT) || (func_ff == FUNC_QUERY);
   assign addr_ok   = (32'(addr_ff) < STORE_BYTES);
   assign mem_addr  = is_probe ? acc_ff[IDX_W-1:3] : ADDR_W'(addr_ff);
   // A byte that has not been written since the last clear reads as zero.
   assign byte_val  = vld_q_ff ? mem_q_ff : 8'h00;
   assign mem_we    = (cmd.byte_wr && addr_ok) ||
                      (cmd.probe_upd && func_ff == FUNC_INSERT);
   assign mem_wdata = cmd.probe_upd ? (byte_val | (8'h01 << acc_ff[2:0])) : data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= func_type'(req_func);
         id1_ff    <= req_node_id;
         id2_ff    <= req_node_id ^ salt_ff;
         uplink_ff <= req_uplink;
         id_nz_ff  <= (req_node_id != '0);
         addr_ff   <= req_byte_index;
         data_ff   <= req_byte_data;
         h1_ff     <= IDX_W'(FNV_OFFSET);
         h2_ff     <= IDX_W'(FNV_OFFSET);
         hit_ff    <= (func_type'(req_func) == FUNC_QUERY);
         rd_ff     <= 8'h00;
      end else begin
         if (cmd.hash) begin
            h1_ff  <= h1_in;
            h2_ff  <= h2_in;
            id1_ff <= id1_ff << 8;
            id2_ff <= id2_ff << 8;
         end
         if (cmd.hash_last) begin
            acc_ff <= h1_in;
         end else if (cmd.probe_upd) begin
            acc_ff <= acc_ff + h2_ff;
         end
         if (cmd.probe_upd && func_ff == FUNC_QUERY && !byte_val[acc_ff[2:0]]) begin
            hit_ff <= 1'b0;
         end
         if (cmd.rd_done) begin
            rd_ff <= addr_ok ? byte_val : 8'h00;
         end
      end
   end

   // Single-port byte store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_addr];
      vld_q_ff <= vld_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_addr] <= 1'b1;
      end
   end

   assign stat.func   = func_ff;
   assign stat.ins_ok = uplink_ff && id_nz_ff;
   assign hit         = hit_ff;
   assign read_data   = rd_ff;

   a_one_store_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.byte_wr, cmd.probe_upd}))
      else $error("more than one store operation in a cycle");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (vld_ff == '0))
      else $error("store not empty after clear");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (func_ff == FUNC_QUERY) |-> !mem_we)
      else $error("store written during a query");

endmodule

### rtl/core/bloom_filter_fnv1a_double_hash.sv
// Channel   Dir  Beat fields (low bit up)
// req_      in   tuser: func[2:0]; tdata: node_id, slot_is_uplink, byte_index, byte_data
// rsp_      out  tdata: hit, read_data, zero fill to 16 bits
// csr_      in   data: second_hash_salt, always ready
//
// One request is worked at a time; the next is taken once the response beat has gone.
// After decode, clear, byte write and an ignored insert go straight to the response;
// a byte read first latches the byte; an insert or query runs the byte-serial FNV-1a unit,
// then a read, and for an insert a write, of the single-port store per probe.
// Synchronous reset empties the store at once through per-byte valid bits and zeroes
// the salt. A stalled response holds the block in its response state.
module bloom_filter_fnv1a_double_hash
   import bloomf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // node_id, slot_is_uplink, byte_index, byte_data
   input  logic [2:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // hit, read_data, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   cmd_type    cmd;
   stat_type   stat;
   logic       hit;
   logic [7:0] read_data;

   assign csr_ready = 1'b1;

   bloomf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bloomf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .req_func       (req_tuser),
      .req_node_id    (req_tdata[63:0]),
      .req_uplink     (req_tdata[64]),
      .req_byte_index (req_tdata[71:65]),
      .req_byte_data  (req_tdata[79:72]),
      .cmd            (cmd),
      .stat           (stat),
      .hit            (hit),
      .read_data      (read_data)
   );

   assign rsp_tdata = {7'b0, read_data, hit};

endmodule
